// ===== rtl/rcas_pkg.sv =====
// ----------------------------------------------------------------------------
// Reply collector package
// Shared types, opcodes and commands for the reply collector and its cells.
// ----------------------------------------------------------------------------
package rcas_pkg;

    localparam logic [1:0] CMD_FRAME = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    localparam logic [7:0] OP_POSITION = 8'h94;
    localparam logic [7:0] OP_VOLTAGE  = 8'h45;
    localparam logic [7:0] OP_MTEMP    = 8'h5F;
    localparam logic [7:0] OP_DTEMP    = 8'h60;

    localparam logic [15:0] LIFETIME_RESET = 16'd100;
    localparam logic [3:0]  ALL_KINDS      = 4'hF;

    typedef struct packed {
        logic [7:0]  node;
        logic [63:0] bytes;
        logic [15:0] life;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic put;
        logic wr;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_START,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  node_id;
        logic [7:0]  opcode;
        logic [55:0] payload;
        logic [15:0] wait_ticks;
    } in_item_t;

    typedef struct packed {
        logic               success;
        logic signed [23:0] position_raw;
        logic signed [15:0] speed_raw;
        logic signed [15:0] current_raw;
        logic signed [15:0] voltage_raw;
        logic signed [15:0] motor_temp_raw;
        logic signed [15:0] driver_temp_raw;
    } out_item_t;

    function automatic logic [3:0] kind_mask(input logic [7:0] op);
        logic [3:0] m;
        m = 4'd0;
        case (op)
            OP_POSITION: m = 4'b0001;
            OP_VOLTAGE:  m = 4'b0010;
            OP_MTEMP:    m = 4'b0100;
            OP_DTEMP:    m = 4'b1000;
            default:     m = 4'd0;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/rcas_if.sv =====
// ----------------------------------------------------------------------------
// Reply collector channels
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface rcas_req_if import rcas_pkg::*;;
    logic     valid;
    logic     ready;
    in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface rcas_rsp_if import rcas_pkg::*;;
    logic      valid;
    logic      ready;
    out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/rcas_cell.sv =====
// ----------------------------------------------------------------------------
// Store cell
// One entry of the oldest-first frame store; shifts toward the head.
// ----------------------------------------------------------------------------
module rcas_cell import rcas_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctrl_t       ctrl,
    input  logic [CNT_W-1:0] len,
    input  entry_t           new_entry,
    input  entry_t           head_entry,
    input  logic             nb_valid,
    input  entry_t           nb_data,
    output logic             q_valid,
    output entry_t           q_data
);

    localparam logic [CNT_W-1:0] POS      = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] NEXT_POS = CNT_W'(IDX + 1);

    logic   valid_reg;
    logic   valid_next;
    entry_t data_reg;
    entry_t data_next;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (ctrl.wr && len == POS)
        begin
            valid_next = 1'b1;
            data_next  = new_entry;
        end
        else if (ctrl.shift)
        begin
            if (ctrl.put && len == NEXT_POS)
            begin
                valid_next = 1'b1;
                data_next  = head_entry;
            end
            else
            begin
                valid_next = nb_valid;
                data_next  = nb_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q_valid = valid_reg;
    assign q_data  = data_reg;

endmodule

// ===== rtl/reply_collector_with_aging_store_core.sv =====
// ----------------------------------------------------------------------------
// Reply collector with aging store
// Stores frames oldest first, ages them on ticks and collects four replies.
// ----------------------------------------------------------------------------
// A frame is handled in the idle state; a tick or start scans the stored
// frames, as each frame passes once through the head cell of the chain.
// A result passes through the emit state and then sits in the output
// register until taken. One item is worked on at a time.
// Reset empties the store, clears the collection state and sets the lifetime
// to 100 at once; no clearing pass is needed.
module reply_collector_with_aging_store_core import rcas_pkg::*;
#(
    parameter int STORE_DEPTH = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_wdata,
    rcas_req_if.sink          req,
    rcas_rsp_if.source        rsp
);

    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STORE_DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic             collecting_reg, collecting_next;
    logic [15:0]      wait_reg, wait_next;
    logic [7:0]       target_reg, target_next;
    logic [3:0]       got_reg, got_next;
    logic [23:0]      pos_reg, pos_next;
    logic [31:0]      motion_reg, motion_next;
    logic [47:0]      levels_reg, levels_next;
    logic [15:0]      lifetime_reg;
    logic             ok_reg, ok_next;
    logic             rsp_valid_reg, rsp_valid_next;
    out_item_t        rsp_item_reg, rsp_item_next;

    cell_ctrl_t       ctrl;
    entry_t           new_entry;
    entry_t           head_entry;
    logic             take_en;
    logic [3:0]       take_mask;
    logic [55:0]      take_pay;
    logic [3:0]       in_mask;
    logic [3:0]       head_mask;
    logic [15:0]      life_dec;

    logic             cell_valid [STORE_DEPTH+1];
    entry_t           cell_data  [STORE_DEPTH+1];

    assign cell_valid[STORE_DEPTH] = 1'b0;
    assign cell_data[STORE_DEPTH]  = '0;

    genvar gi;
    generate
        for (gi = 0; gi < STORE_DEPTH; gi++)
        begin : g_cell
            rcas_cell #(
                .IDX   (gi),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .len        (len_reg),
                .new_entry  (new_entry),
                .head_entry (head_entry),
                .nb_valid   (cell_valid[gi+1]),
                .nb_data    (cell_data[gi+1]),
                .q_valid    (cell_valid[gi]),
                .q_data     (cell_data[gi])
            );
        end
    endgenerate

    assign in_mask   = kind_mask(req.payload.opcode);
    assign head_mask = kind_mask(cell_data[0].bytes[63:56]);
    assign life_dec  = cell_data[0].life - 16'd1;
    assign new_entry = '{node:  req.payload.node_id,
                         bytes: {req.payload.opcode, req.payload.payload},
                         life:  lifetime_reg};

    always_comb
    begin
        state_next      = state_reg;
        len_next        = len_reg;
        remain_next     = remain_reg;
        collecting_next = collecting_reg;
        wait_next       = wait_reg;
        target_next     = target_reg;
        ok_next         = ok_reg;
        ctrl            = '0;
        head_entry      = cell_data[0];
        take_en         = 1'b0;
        take_mask       = in_mask;
        take_pay        = req.payload.payload;
        req.ready       = (state_reg == ST_IDLE);
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_item_next   = rsp_item_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.payload.command)
                        CMD_FRAME:
                        begin
                            if (collecting_reg && req.payload.node_id == target_reg
                                && in_mask != 4'd0)
                            begin
                                take_en = 1'b1;
                                if ((got_reg | in_mask) == ALL_KINDS)
                                begin
                                    collecting_next = 1'b0;
                                    ok_next         = 1'b1;
                                    state_next      = ST_EMIT;
                                end
                            end
                            else if (len_reg < DEPTH_C)
                            begin
                                ctrl.wr  = 1'b1;
                                len_next = len_reg + ONE_C;
                            end
                        end
                        CMD_TICK:
                        begin
                            if (wait_reg != 16'd0)
                            begin
                                wait_next = wait_reg - 16'd1;
                            end
                            remain_next = len_reg;
                            state_next  = ST_TICK;
                        end
                        CMD_START:
                        begin
                            collecting_next = 1'b1;
                            target_next     = req.payload.node_id;
                            wait_next       = req.payload.wait_ticks;
                            if (req.payload.wait_ticks == 16'd0)
                            begin
                                collecting_next = 1'b0;
                                ok_next         = 1'b0;
                                state_next      = ST_EMIT;
                            end
                            else
                            begin
                                remain_next = len_reg;
                                state_next  = ST_START;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_TICK:
            begin
                if (remain_reg == '0)
                begin
                    if (collecting_reg && wait_reg == 16'd0)
                    begin
                        collecting_next = 1'b0;
                        ok_next         = 1'b0;
                        state_next      = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    head_entry.life = life_dec;
                    ctrl.shift      = 1'b1;
                    ctrl.put        = (life_dec != 16'd0);
                    if (life_dec == 16'd0)
                    begin
                        len_next = len_reg - ONE_C;
                    end
                    remain_next = remain_reg - ONE_C;
                end
            end
            ST_START:
            begin
                if (remain_reg == '0)
                begin
                    if (got_reg == ALL_KINDS)
                    begin
                        collecting_next = 1'b0;
                        ok_next         = 1'b1;
                        state_next      = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    ctrl.shift = 1'b1;
                    ctrl.put   = 1'b1;
                    if (got_reg != ALL_KINDS && cell_data[0].node == target_reg
                        && head_mask != 4'd0)
                    begin
                        ctrl.put  = 1'b0;
                        take_en   = 1'b1;
                        take_mask = head_mask;
                        take_pay  = cell_data[0].bytes[55:0];
                        len_next  = len_reg - ONE_C;
                    end
                    remain_next = remain_reg - ONE_C;
                end
            end
            ST_EMIT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    if (ok_reg)
                    begin
                        rsp_item_next = '{success:         1'b1,
                                          position_raw:    pos_reg,
                                          speed_raw:       motion_reg[31:16],
                                          current_raw:     motion_reg[15:0],
                                          voltage_raw:     levels_reg[47:32],
                                          motor_temp_raw:  levels_reg[31:16],
                                          driver_temp_raw: levels_reg[15:0]};
                    end
                    else
                    begin
                        rsp_item_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        got_next    = got_reg;
        pos_next    = pos_reg;
        motion_next = motion_reg;
        levels_next = levels_reg;
        if (state_reg == ST_IDLE && req.valid && req.payload.command == CMD_START)
        begin
            got_next = 4'd0;
        end
        if (take_en)
        begin
            got_next = got_reg | take_mask;
            if (take_mask[0])
            begin
                pos_next    = take_pay[55:32];
                motion_next = take_pay[31:0];
            end
            if (take_mask[1])
            begin
                levels_next[47:32] = take_pay[55:40];
            end
            if (take_mask[2])
            begin
                levels_next[31:16] = take_pay[55:40];
            end
            if (take_mask[3])
            begin
                levels_next[15:0] = take_pay[55:40];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            len_reg        <= '0;
            remain_reg     <= '0;
            collecting_reg <= 1'b0;
            wait_reg       <= 16'd0;
            target_reg     <= 8'd0;
            got_reg        <= 4'd0;
            pos_reg        <= 24'd0;
            motion_reg     <= 32'd0;
            levels_reg     <= 48'd0;
            lifetime_reg   <= LIFETIME_RESET;
            ok_reg         <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            len_reg        <= len_next;
            remain_reg     <= remain_next;
            collecting_reg <= collecting_next;
            wait_reg       <= wait_next;
            target_reg     <= target_next;
            got_reg        <= got_next;
            pos_reg        <= pos_next;
            motion_reg     <= motion_next;
            levels_reg     <= levels_next;
            ok_reg         <= ok_next;
            rsp_valid_reg  <= rsp_valid_next;
            if (cfg_we)
            begin
                lifetime_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_item_reg <= rsp_item_next;
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_item_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= DEPTH_C)
        else $error("Store fill count exceeds the store depth.");

    a_remain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TICK || state_reg == ST_START) |-> remain_reg <= len_reg)
        else $error("Scan count exceeds the number of stored frames.");

    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_TICK || state_reg == ST_START) && remain_reg != '0)
        |-> cell_valid[0])
        else $error("The head cell is empty while frames remain to be scanned.");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_item_reg.success) |-> rsp_item_reg == '0)
        else $error("A failure result carries nonzero values.");

    a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !collecting_reg)
        else $error("A result is pending while a collection is still active.");

endmodule

// ===== tb/sv/reply_collector_with_aging_store_core_tb.sv =====
// ----------------------------------------------------------------------------
// Reply collector with aging store testbench
// Drives frames, ticks, start requests and unknown commands with random gaps,
// predicts each result with a behavioral copy of the store and collection
// state, and compares every result transfer with the prediction in arrival order.
// ----------------------------------------------------------------------------
module reply_collector_with_aging_store_core_tb;
    import rcas_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;
    localparam int CYCLE_LIMIT = 3000000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [15:0] cfg_wdata;

    rcas_req_if req ();
    rcas_rsp_if rsp ();

    reply_collector_with_aging_store_core #(.STORE_DEPTH(DEPTH)) dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .req(req.sink), .rsp(rsp.source)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Predictor state.
    logic        st_valid [DEPTH];
    logic [7:0]  st_node [DEPTH];
    logic [63:0] st_bytes [DEPTH];
    logic [15:0] st_life [DEPTH];
    int          st_rank [DEPTH];
    logic        busy_collect;
    logic [15:0] wait_count;
    logic [7:0]  want_node;
    logic [3:0]  seen_kinds;
    logic [23:0] keep_pos;
    logic [31:0] keep_motion;
    logic [47:0] keep_levels;
    logic [15:0] life_setting;

    in_item_t  pending_items [$];
    out_item_t expected_results [$];
    int        mismatches;
    int        cycle_count;
    bit        hold_sink;
    int        hold_cycles;
    bit        req_fire;

    function automatic int kind_index(input logic [7:0] op);
        case (op)
            OP_POSITION: return 0;
            OP_VOLTAGE:  return 1;
            OP_MTEMP:    return 2;
            OP_DTEMP:    return 3;
            default:     return -1;
        endcase
    endfunction

    function automatic void release_entry(input int s);
        int r;
        r = st_rank[s];
        st_valid[s] = 1'b0;
        for (int i = 0; i < DEPTH; i++)
            if (st_valid[i] && st_rank[i] > r) st_rank[i]--;
    endfunction

    function automatic void absorb(input int k, input logic [55:0] p);
        case (k)
            0:
            begin
                keep_pos = p[55:32];
                keep_motion = p[31:0];
            end
            1: keep_levels[47:32] = p[55:40];
            2: keep_levels[31:16] = p[55:40];
            default: keep_levels[15:0] = p[55:40];
        endcase
        seen_kinds[k] = 1'b1;
    endfunction

    function automatic void push_result(input bit ok);
        out_item_t o;
        busy_collect = 1'b0;
        o = '0;
        o.success = ok;
        if (ok)
        begin
            o.position_raw = keep_pos;
            o.speed_raw = keep_motion[31:16];
            o.current_raw = keep_motion[15:0];
            o.voltage_raw = keep_levels[47:32];
            o.motor_temp_raw = keep_levels[31:16];
            o.driver_temp_raw = keep_levels[15:0];
        end
        expected_results.push_back(o);
    endfunction

    function automatic void predict(input in_item_t it);
        int k;
        int n;
        int order_list [DEPTH];
        n = 0;
        if (it.command == CMD_FRAME)
        begin
            k = kind_index(it.opcode);
            if (busy_collect && it.node_id == want_node && k >= 0)
            begin
                absorb(k, it.payload);
                if (seen_kinds == ALL_KINDS) push_result(1'b1);
                return;
            end
            for (int i = 0; i < DEPTH; i++) if (st_valid[i]) n++;
            if (n >= DEPTH) return;
            for (int i = 0; i < DEPTH; i++)
                if (!st_valid[i])
                begin
                    st_valid[i] = 1'b1;
                    st_node[i] = it.node_id;
                    st_bytes[i] = {it.opcode, it.payload};
                    st_life[i] = life_setting;
                    st_rank[i] = n;
                    break;
                end
        end
        else if (it.command == CMD_TICK)
        begin
            if (wait_count != 0) wait_count--;
            for (int i = 0; i < DEPTH; i++)
                if (st_valid[i])
                begin
                    st_life[i] = st_life[i] - 16'd1;
                    if (st_life[i] == 0) release_entry(i);
                end
            if (busy_collect && wait_count == 0) push_result(1'b0);
        end
        else if (it.command == CMD_START)
        begin
            busy_collect = 1'b1;
            want_node = it.node_id;
            wait_count = it.wait_ticks;
            seen_kinds = 4'd0;
            if (it.wait_ticks == 0)
            begin
                push_result(1'b0);
                return;
            end
            for (int i = 0; i < DEPTH; i++)
                if (st_valid[i])
                begin
                    order_list[st_rank[i]] = i;
                    n++;
                end
            for (int r = 0; r < n; r++)
            begin
                int s;
                s = order_list[r];
                if (st_node[s] != want_node) continue;
                k = kind_index(st_bytes[s][63:56]);
                if (k < 0) continue;
                absorb(k, st_bytes[s][55:0]);
                release_entry(s);
                if (seen_kinds == ALL_KINDS)
                begin
                    push_result(1'b1);
                    return;
                end
            end
        end
    endfunction

    // Driver.
    int src_gap;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.payload <= '0;
            src_gap <= 0;
        end
        else if (!req.valid || req_fire)
        begin
            if (src_gap > 0)
            begin
                req.valid <= 1'b0;
                src_gap <= src_gap - 1;
            end
            else if (pending_items.size() > 0)
            begin
                req.valid <= 1'b1;
                req.payload <= pending_items.pop_front();
                src_gap <= $urandom_range(0, 3) == 0 ? $urandom_range(0, 14) : 0;
            end
            else
                req.valid <= 1'b0;
        end
    end

    // Transfers at rising edge: predict on input, check on output.
    always @(posedge clk)
    begin
        req_fire <= rst_n && req.valid && req.ready;
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (req.valid && req.ready) predict(req.payload);
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result transfer: %p", rsp.payload);
                end
                else
                begin
                    out_item_t e;
                    e = expected_results.pop_front();
                    if (e !== rsp.payload)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Result mismatch: expected %p actual %p", e, rsp.payload);
                    end
                end
            end
        end
    end

    // Receiver with random stalls and a long hold-off on request.
    int sink_gap;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            sink_gap <= 0;
            hold_cycles <= 0;
        end
        else if (hold_sink && hold_cycles < 400)
        begin
            rsp.ready <= 1'b0;
            hold_cycles <= hold_cycles + 1;
        end
        else if (sink_gap > 0)
        begin
            rsp.ready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end
        else
        begin
            rsp.ready <= 1'b1;
            if (rsp.valid && rsp.ready)
                sink_gap <= $urandom_range(0, 3) == 0 ? $urandom_range(0, 14) : 0;
        end
    end

    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic in_item_t make_item(input logic [1:0] c, input logic [7:0] nd,
                                           input logic [7:0] op, input logic [55:0] p,
                                           input logic [15:0] w);
        in_item_t it;
        it.command = c;
        it.node_id = nd;
        it.opcode = op;
        it.payload = p;
        it.wait_ticks = w;
        return it;
    endfunction

    function automatic logic [55:0] rand_payload();
        return 56'({$urandom(), $urandom()});
    endfunction

    function automatic logic [7:0] reply_op(input int k);
        case (k)
            0: return OP_POSITION;
            1: return OP_VOLTAGE;
            2: return OP_MTEMP;
            default: return OP_DTEMP;
        endcase
    endfunction

    task automatic drain();
        while (pending_items.size() > 0 || req.valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_lifetime(input logic [15:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        life_setting = v;
    endtask

    task automatic random_phase(input int count);
        int made;
        logic [7:0] nd;
        made = 0;
        while (made < count)
        begin
            int sel;
            sel = $urandom_range(0, 9);
            nd = 8'($urandom_range(0, 3));
            if (sel < 4)
            begin
                // Exchange: start, then up to four replies of random kind, some from other nodes, with ticks between.
                pending_items.push_back(make_item(CMD_START, nd, 8'h00, rand_payload(),
                    $urandom_range(0, 7) == 0 ? 16'd0 : 16'($urandom_range(1, 6))));
                for (int k = 0; k < 4; k++)
                begin
                    if ($urandom_range(0, 5) == 0) continue;
                    pending_items.push_back(make_item(CMD_FRAME,
                        $urandom_range(0, 4) == 0 ? 8'($urandom()) : nd,
                        reply_op($urandom_range(0, 3)), rand_payload(), 16'($urandom())));
                    if ($urandom_range(0, 3) == 0)
                        pending_items.push_back(make_item(CMD_TICK, 8'($urandom()),
                            8'($urandom()), rand_payload(), 16'($urandom())));
                end
                made += 5;
            end
            else if (sel < 7)
            begin
                pending_items.push_back(make_item(CMD_FRAME, nd,
                    $urandom_range(0, 2) == 0 ? 8'($urandom()) : reply_op($urandom_range(0, 3)),
                    rand_payload(), 16'($urandom())));
                made++;
            end
            else if (sel < 9)
            begin
                pending_items.push_back(make_item(CMD_TICK, 8'($urandom()), 8'($urandom()),
                    rand_payload(), 16'($urandom())));
                made++;
            end
            else
            begin
                pending_items.push_back(make_item(2'd3, 8'($urandom()), 8'($urandom()),
                    rand_payload(), 16'($urandom())));
            end
            while (pending_items.size() > 40) @(posedge clk);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        hold_sink = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            st_valid[i] = 1'b0;
            st_node[i] = '0;
            st_bytes[i] = '0;
            st_life[i] = '0;
            st_rank[i] = 0;
        end
        busy_collect = 1'b0;
        wait_count = '0;
        want_node = '0;
        seen_kinds = '0;
        keep_pos = '0;
        keep_motion = '0;
        keep_levels = '0;
        life_setting = LIFETIME_RESET;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset lifetime.
        pending_items.push_back(make_item(CMD_START, 8'd5, 8'd0, '0, 16'd0));
        pending_items.push_back(make_item(CMD_TICK, 8'd0, 8'd0, '0, 16'd0));
        pending_items.push_back(make_item(CMD_FRAME, 8'hFF, OP_POSITION, '1, 16'hFFFF));
        pending_items.push_back(make_item(CMD_FRAME, 8'hFF, OP_VOLTAGE,
            56'h80_0000_0000_0000, 16'd0));
        pending_items.push_back(make_item(CMD_FRAME, 8'hFF, 8'h00, '0, 16'd0));
        pending_items.push_back(make_item(CMD_FRAME, 8'hFF, OP_MTEMP,
            56'h7F_FF00_0000_0000, 16'd0));
        pending_items.push_back(make_item(CMD_FRAME, 8'hFF, OP_DTEMP,
            56'h12_3400_0000_0000, 16'd0));
        pending_items.push_back(make_item(CMD_START, 8'hFF, 8'h00, '0, 16'hFFFF));
        pending_items.push_back(make_item(CMD_START, 8'h00, 8'h00, '0, 16'd2));
        pending_items.push_back(make_item(CMD_START, 8'h01, 8'h00, '0, 16'd1));
        pending_items.push_back(make_item(CMD_FRAME, 8'h01, OP_POSITION,
            56'h00_0001_0002_0003, 16'd0));
        pending_items.push_back(make_item(CMD_FRAME, 8'h01, OP_POSITION,
            56'h55_AA55_AA55_AA55, 16'd0));
        pending_items.push_back(make_item(CMD_TICK, 8'hFF, 8'hFF, '1, 16'hFFFF));
        pending_items.push_back(make_item(2'd3, 8'hFF, 8'hFF, '1, 16'hFFFF));
        for (int i = 0; i < 18; i++)
            pending_items.push_back(make_item(CMD_FRAME, 8'd7, 8'($urandom()),
                rand_payload(), 16'd0));
        drain();

        // Lifetime zero: stored frames wrap on their first tick.
        set_lifetime(16'd0);
        for (int i = 0; i < 4; i++)
            pending_items.push_back(make_item(CMD_FRAME, 8'd9, 8'($urandom()),
                rand_payload(), 16'd0));
        for (int i = 0; i < 20; i++)
            pending_items.push_back(make_item(CMD_TICK, 8'd0, 8'd0, '0, 16'd0));
        drain();

        // Long receiver stall with the store filling behind it.
        set_lifetime(16'hFFFF);
        hold_sink = 1'b1;
        random_phase(150);
        drain();
        hold_sink = 1'b0;

        set_lifetime(16'd1);
        random_phase(300);
        drain();
        set_lifetime(16'd3);
        random_phase(700);
        drain();
        set_lifetime(16'd12);
        random_phase(700);
        drain();
        set_lifetime(LIFETIME_RESET);
        random_phase(200);
        drain();

        if (mismatches == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/rcas_pkg.sv
rtl/rcas_if.sv
rtl/rcas_cell.sv
rtl/reply_collector_with_aging_store_core.sv
tb/sv/reply_collector_with_aging_store_core_tb.sv
